### sv/dfrr_pkg.sv
// Package for the delimited frame receiver ring: sizes, delimiter codes
// and the sequencer state type. No dependencies.
`default_nettype none

package dfrr_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int MAX_LEN   = 64;
  localparam int OUT_CAP   = 64;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(NUM_SLOTS * MAX_LEN);
  // wide enough for any length or for OUT_CAP
  localparam int CMP_W  = 9;

  localparam logic [7:0] START_CHAR = 8'h2A;
  localparam logic [7:0] END_CHAR   = 8'h23;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } seq_state_t;

endpackage

`default_nettype wire

### sv/delimited_frame_receiver_ring_core.sv
// Delimited frame receiver with a ring of message slots.
// Depends on dfrr_pkg; holds the payload memory and the readout sequencer.
`default_nettype none

// Each transfer on start/busy is a received byte or a consumer poll. A byte
// gives no result. A poll with no complete message ready gives one not-found
// result in the following cycle. A poll on a ready slot keeps busy high while
// its stored bytes are read (the single payload memory port reads each byte
// and clears it behind itself), with results one per cycle after the poll has
// passed the state register and then the memory read and output registers.
// Results are strobed on out_valid for one cycle and cannot be held off. No
// clearing pass is run after reset.
module delimited_frame_receiver_ring_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_req_type,
  input  wire logic [7:0]                 in_rx_byte,
  output logic                            out_valid,
  output logic                            out_found,
  output logic [7:0]                      out_data_byte,
  output logic [5:0]                      out_byte_pos,
  output logic                            out_last
);
  import dfrr_pkg::*;

  seq_state_t state_r, state_nxt;

  logic              receiving_r, receiving_nxt;
  logic [POS_W-1:0]  write_pos_r, write_pos_nxt;
  logic [SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [SLOT_W-1:0] read_slot_r, read_slot_nxt;
  logic [NUM_SLOTS-1:0] slot_ready_r, slot_ready_nxt;
  logic [POS_W-1:0]  slot_length_r [NUM_SLOTS];
  logic              len_we;
  logic [POS_W-1:0]  len_wdata;

  logic [ADDR_W-1:0] rd_base_r, rd_base_nxt;
  logic [POS_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [POS_W-1:0]  rd_len_r, rd_len_nxt;
  logic [POS_W-1:0]  rd_n_r, rd_n_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [5:0]        out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;

  logic [7:0]        payload_mem [NUM_SLOTS*MAX_LEN];
  logic [7:0]        mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;

  logic              accept;
  logic [CMP_W-1:0]  cur_len_w, cur_n_w, pos_inc_w;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cur_len_w = CMP_W'(slot_length_r[read_slot_r]);
    cur_n_w   = (cur_len_w > CMP_W'(OUT_CAP)) ? CMP_W'(OUT_CAP) : cur_len_w;
    pos_inc_w = CMP_W'(write_pos_r) + CMP_W'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    receiving_nxt  = receiving_r;
    write_pos_nxt  = write_pos_r;
    write_slot_nxt = write_slot_r;
    read_slot_nxt  = read_slot_r;
    slot_ready_nxt = slot_ready_r;
    rd_base_nxt    = rd_base_r;
    rd_idx_nxt     = rd_idx_r;
    rd_len_nxt     = rd_len_r;
    rd_n_nxt       = rd_n_r;
    len_we         = 1'b0;
    len_wdata      = write_pos_nxt;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = ADDR_W'(write_slot_r) * ADDR_W'(MAX_LEN) + ADDR_W'(write_pos_r);
    mem_raddr      = rd_base_r + ADDR_W'(rd_idx_r);
    mem_wdata      = in_rx_byte;
    out_valid_nxt  = 1'b0;
    out_found_nxt  = 1'b0;
    out_pos_nxt    = '0;
    out_last_nxt   = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_req_type == REQ_BYTE) begin
          if (in_rx_byte == START_CHAR) begin
            // open or restart a frame at position 0
            receiving_nxt = 1'b1;
            mem_we        = 1'b1;
            mem_waddr     = ADDR_W'(write_slot_r) * ADDR_W'(MAX_LEN);
            write_pos_nxt = POS_W'(1);
          end else if (receiving_r) begin
            mem_we = 1'b1;
            if (in_rx_byte == END_CHAR) begin
              slot_ready_nxt[write_slot_r] = 1'b1;
              len_we         = 1'b1;
              len_wdata      = POS_W'(pos_inc_w);
              write_slot_nxt = (write_slot_r == SLOT_W'(NUM_SLOTS - 1)) ?
                               '0 : write_slot_r + SLOT_W'(1);
              write_pos_nxt  = '0;
              receiving_nxt  = 1'b0;
            end else if (pos_inc_w >= CMP_W'(MAX_LEN)) begin
              // frame too long: drop it
              write_pos_nxt = '0;
              receiving_nxt = 1'b0;
            end else begin
              write_pos_nxt = POS_W'(pos_inc_w);
            end
          end
        end else if (accept && in_req_type == REQ_POLL) begin
          if (slot_ready_r[read_slot_r]) begin
            slot_ready_nxt[read_slot_r] = 1'b0;
            read_slot_nxt = (read_slot_r == SLOT_W'(NUM_SLOTS - 1)) ?
                            '0 : read_slot_r + SLOT_W'(1);
            if (cur_len_w != '0) begin
              state_nxt   = ST_READ;
              rd_base_nxt = ADDR_W'(read_slot_r) * ADDR_W'(MAX_LEN);
              rd_idx_nxt  = '0;
              rd_len_nxt  = POS_W'(cur_len_w);
              rd_n_nxt    = POS_W'(cur_n_w);
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        // read byte and clear it behind the read (read-first memory)
        mem_re    = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = mem_raddr;
        mem_wdata = '0;
        if (CMP_W'(rd_idx_r) < CMP_W'(OUT_CAP)) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = rd_idx_r[5:0];
          out_last_nxt  = (CMP_W'(rd_idx_r) + CMP_W'(1) == CMP_W'(rd_n_r));
        end
        rd_idx_nxt = rd_idx_r + POS_W'(1);
        if (CMP_W'(rd_idx_r) + CMP_W'(1) == CMP_W'(rd_len_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      receiving_r  <= 1'b0;
      write_pos_r  <= '0;
      write_slot_r <= '0;
      read_slot_r  <= '0;
      slot_ready_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      receiving_r  <= receiving_nxt;
      write_pos_r  <= write_pos_nxt;
      write_slot_r <= write_slot_nxt;
      read_slot_r  <= read_slot_nxt;
      slot_ready_r <= slot_ready_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_base_r   <= rd_base_nxt;
    rd_idx_r    <= rd_idx_nxt;
    rd_len_r    <= rd_len_nxt;
    rd_n_r      <= rd_n_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
    if (len_we) begin
      slot_length_r[write_slot_r] <= len_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= payload_mem[mem_raddr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_data_byte = out_found_r ? mem_rdata_r : 8'h00;
  assign out_byte_pos  = out_pos_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  a_poll_answered: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_POLL) |=>
      ((out_valid_r && !out_found_r) || state_r == ST_READ))
    else $error("poll transfer neither answered nor read out");

  a_read_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_READ) |-> $past(accept && in_req_type == REQ_POLL))
    else $error("readout started without a poll");

  a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_last_r && out_pos_r == '0))
    else $error("not-found result malformed");

  a_byte_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_BYTE) |=> (!out_valid_r && state_r == ST_IDLE))
    else $error("received byte produced a result");
`endif

endmodule

`default_nettype wire

### dv/dfrr_checker.sv
// Scoreboard for delimited_frame_receiver_ring_core: watches the command and
// result channels, predicts the readout of each poll and compares per field.
// Depends on dfrr_pkg for sizes, delimiters and request codes.
`timescale 1ns / 100ps

module dfrr_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_found,
  input  wire logic [7:0] out_data_byte,
  input  wire logic [5:0] out_byte_pos,
  input  wire logic       out_last,
  output int              errors,
  output int              outstanding
);
  import dfrr_pkg::*;

  localparam int IDX_W = $clog2(MAX_LEN);

  typedef struct packed {
    logic       found;
    logic [7:0] data_byte;
    logic [5:0] byte_pos;
    logic       last;
  } readout_t;

  localparam readout_t NOT_FOUND = '{found: 1'b0, data_byte: 8'h00, byte_pos: 6'd0,
                                     last: 1'b1};

  readout_t          readout_q[$];
  logic              in_frame;
  logic [POS_W-1:0]  fill_pos;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic              ready     [NUM_SLOTS];
  logic [POS_W-1:0]  frame_len [NUM_SLOTS];
  logic [7:0]        frame_mem [NUM_SLOTS][MAX_LEN];

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(NUM_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  task automatic store_rx_byte(input logic [7:0] b);
    if (b == START_CHAR) begin
      // opens a frame, or restarts the open one
      in_frame = 1'b1;
      frame_mem[wr_slot][0] = b;
      fill_pos = POS_W'(1);
    end else if (in_frame) begin
      if (fill_pos < MAX_LEN) frame_mem[wr_slot][fill_pos[IDX_W-1:0]] = b;
      fill_pos = fill_pos + 1'b1;
      if (b == END_CHAR) begin
        ready[wr_slot]     = 1'b1;
        frame_len[wr_slot] = fill_pos;
        wr_slot  = ring_next(wr_slot);
        fill_pos = '0;
        in_frame = 1'b0;
      end else if (fill_pos >= MAX_LEN) begin
        // full without an end delimiter: frame dropped
        in_frame = 1'b0;
        fill_pos = '0;
      end
    end
  endtask

  task automatic read_out_slot();
    int       len;
    int       n;
    readout_t r;
    n = 0;
    if (ready[rd_slot]) begin
      len = frame_len[rd_slot];
      if (len > MAX_LEN) len = MAX_LEN;
      n = (len > OUT_CAP) ? OUT_CAP : len;
      for (int i = 0; i < len; i++) begin
        if (i < n) begin
          r.found     = 1'b1;
          r.data_byte = frame_mem[rd_slot][IDX_W'(i)];
          r.byte_pos  = 6'(i);
          r.last      = (i == n - 1);
          readout_q.push_back(r);
        end
        frame_mem[rd_slot][IDX_W'(i)] = 8'h00;
      end
      ready[rd_slot] = 1'b0;
      rd_slot = ring_next(rd_slot);
    end
    if (n == 0) readout_q.push_back(NOT_FOUND);
  endtask

  always @(posedge clk) begin
    readout_t exp_r;
    if (!rst_n) begin
      in_frame = 1'b0;
      fill_pos = '0;
      wr_slot  = '0;
      rd_slot  = '0;
      for (int s = 0; s < NUM_SLOTS; s++) ready[s] = 1'b0;
      readout_q.delete();
    end else begin
      if (out_valid) begin
        if (readout_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0b/%02h/%0d/%0b",
                   $time, out_found, out_data_byte, out_byte_pos, out_last);
          errors++;
        end else begin
          exp_r = readout_q.pop_front();
          if (out_found !== exp_r.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, exp_r.found, out_found);
            errors++;
          end
          if (out_data_byte !== exp_r.data_byte) begin
            $display("%0t: data_byte mismatch, expected %02h actual %02h",
                     $time, exp_r.data_byte, out_data_byte);
            errors++;
          end
          if (out_byte_pos !== exp_r.byte_pos) begin
            $display("%0t: byte_pos mismatch, expected %0d actual %0d",
                     $time, exp_r.byte_pos, out_byte_pos);
            errors++;
          end
          if (out_last !== exp_r.last) begin
            $display("%0t: last mismatch, expected %0b actual %0b",
                     $time, exp_r.last, out_last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (in_req_type == REQ_POLL) read_out_slot();
        else store_rx_byte(in_rx_byte);
      end
    end
    outstanding <= readout_q.size();
  end

endmodule

### dv/testbench.sv
// Top of the testbench for delimited_frame_receiver_ring_core: drives bytes
// and polls, runs the watchdog and gives the verdict.
// Depends on dfrr_pkg, the core and dfrr_checker.
`timescale 1ns / 100ps

module testbench;
  import dfrr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET = 470;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       in_req_type = REQ_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic       busy;
  logic       out_valid;
  logic       out_found;
  logic [7:0] out_data_byte;
  logic [5:0] out_byte_pos;
  logic       out_last;

  int errors;
  int outstanding;
  int item_count = 0;
  int idle_pct = 10;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  delimited_frame_receiver_ring_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_data_byte(out_data_byte),
    .out_byte_pos (out_byte_pos),
    .out_last     (out_last)
  );

  dfrr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_data_byte(out_data_byte),
    .out_byte_pos (out_byte_pos),
    .out_last     (out_last),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  // any transfer on either channel resets the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send(input logic req, input logic [7:0] b);
    @(negedge clk);
    start       <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(7)) @(negedge clk);
    end
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == START_CHAR || b == END_CHAR) b ^= 8'h01;
    return b;
  endfunction

  task automatic send_poll();
    send(REQ_POLL, 8'($urandom_range(255)));
  endtask

  // body_len bytes after the start delimiter, then the end one if closed; optionally a poll inside
  task automatic send_frame(input int body_len, input bit closed, input bit mid_poll);
    int poll_at;
    poll_at = mid_poll ? int'($urandom_range(body_len)) : -1;
    send(REQ_BYTE, START_CHAR);
    for (int i = 0; i < body_len; i++) begin
      if (i == poll_at) send_poll();
      send(REQ_BYTE, body_byte());
    end
    if (poll_at == body_len) send_poll();
    if (closed) send(REQ_BYTE, END_CHAR);
  endtask

  function automatic int short_body();
    int pick;
    pick = $urandom_range(99);
    if (pick < 90) return $urandom_range(8);
    if (pick < 96) return $urandom_range(61, 9);
    return MAX_LEN - 2;
  endfunction

  initial begin
    int pick;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty poll, stray bytes, shortest frame, restart, extremes
    send(REQ_POLL, 8'h00);
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, 8'hFF);
    send(REQ_BYTE, END_CHAR);
    send(REQ_BYTE, START_CHAR);
    send(REQ_BYTE, END_CHAR);
    send(REQ_POLL, 8'hFF);
    send(REQ_BYTE, START_CHAR);
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, START_CHAR);
    send(REQ_BYTE, 8'hFF);
    send(REQ_BYTE, 8'h00);
    send(REQ_BYTE, END_CHAR);
    send(REQ_POLL, 8'h55);
    send(REQ_POLL, 8'hAA);

    // random part opens with a longest frame and an overlong, dropped one
    send_frame(MAX_LEN - 2, 1'b1, 1'b0);
    send_frame(MAX_LEN - 1, 1'b0, 1'b0);
    send(REQ_BYTE, END_CHAR);
    send_poll();
    send_poll();

    while (item_count < ITEM_TARGET) begin
      idle_pct = (item_count < ITEM_TARGET / 3) ? 10 :
                 (item_count < 2 * ITEM_TARGET / 3) ? 62 : 0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(short_body(), 1'b1, $urandom_range(9) == 0);
      end else if (pick < 77) begin
        repeat ($urandom_range(4, 1)) send_poll();
      end else if (pick < 85) begin
        send(REQ_BYTE, 8'($urandom_range(255)));
      end else if (pick < 95) begin
        // broken frame: cut short, or run past the length limit
        if ($urandom_range(3) == 0) send_frame(MAX_LEN - 1, 1'b0, 1'b0);
        else send_frame($urandom_range(5), 1'b0, 1'b0);
      end else begin
        // fill the whole ring and beyond so unread slots are overwritten
        repeat (NUM_SLOTS + $urandom_range(2)) send_frame($urandom_range(4), 1'b1, 1'b0);
        send_frame($urandom_range(6, 1), 1'b1, 1'b1);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
sv/dfrr_pkg.sv
sv/delimited_frame_receiver_ring_core.sv
dv/dfrr_checker.sv
dv/testbench.sv
